@@ rtl/poly6_value_and_slope_macros.svh @@
// assertion macros shared by the poly6 value and slope rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef POLY6_VALUE_AND_SLOPE_MACROS_SVH
`define POLY6_VALUE_AND_SLOPE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define P6VS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("p6vs assertion failed");
// next-cycle implication
`define P6VS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("p6vs assertion failed");
`else
`define P6VS_ASSERT_SAME(label, clk, rst, ante, cons)
`define P6VS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/p6vs_pkg.sv @@
// shared types and constants for the degree-6 polynomial value and slope pipeline
// no dependencies
package p6vs_pkg;

  localparam int NUM_COEF  = 7;
  localparam int NUM_STEPS = 6;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int ADDR_W    = 5;
  localparam int IDX_W     = 3;

  // coefficient register indexes
  localparam logic [IDX_W-1:0] REG_A0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_A1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_A2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_A3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_A4 = 3'd4;
  localparam logic [IDX_W-1:0] REG_A5 = 3'd5;
  localparam logic [IDX_W-1:0] REG_A6 = 3'd6;

  localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // one transaction in flight between horner steps
  typedef struct packed {
    logic                     vld;
    logic                     ovf;
    logic                     x_neg;
    logic [DATA_W-1:0]        x_mag;
    logic signed [ACC_W-1:0]  val;
    logic signed [ACC_W-1:0]  der;
  } p6vs_item_t;

  // per-step coefficient addends for both lanes
  typedef struct packed {
    logic signed [ACC_W-1:0] val;
    logic signed [ACC_W-1:0] der;
  } p6vs_addend_t;

endpackage

@@ rtl/p6vs_horner_step.sv @@
// one horner step acc <- sat(rnd(acc * x)) + c for the value lane and, if SLOPE_ON, the slope lane, 4 stages
// depends on p6vs_pkg and poly6_value_and_slope_macros.svh
`include "poly6_value_and_slope_macros.svh"
module p6vs_horner_step #(
  parameter int FRAC_BITS = 16,
  parameter bit SLOPE_ON  = 1'b1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  p6vs_pkg::p6vs_item_t   item_in,
  input  p6vs_pkg::p6vs_addend_t addend,
  output p6vs_pkg::p6vs_item_t   item_out
);
  import p6vs_pkg::*;

  localparam int PROD_W = ACC_W + DATA_W;
  localparam logic [PROD_W-1:0] RND_ONE = PROD_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic              vld;
    logic              ovf;
    logic              x_neg;
    logic [DATA_W-1:0] x_mag;
  } ctl_t;

  typedef struct packed {
    logic             aneg;
    logic [ACC_W-1:0] ua;
  } mag_t;

  typedef struct packed {
    logic             neg;
    logic [ACC_W-1:0] plo;
    logic [ACC_W-1:0] phi;
  } mul_t;

  typedef struct packed {
    logic             neg;
    logic             povf;
    logic [ACC_W-1:0] mlo;
  } rnd_t;

  typedef struct packed {
    logic                    aovf;
    logic signed [ACC_W-1:0] acc;
  } sum_t;

  function automatic mag_t mag_f(logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] bits;
    mag_t o;
    bits   = acc;
    o.aneg = acc[ACC_W-1];
    o.ua   = o.aneg ? (~bits + ACC_W'(1)) : bits;
    return o;
  endfunction

  // two 32x32 partial products of |acc| * |x|
  function automatic mul_t mul_f(mag_t m, logic [DATA_W-1:0] x_mag, logic x_neg);
    mul_t o;
    o.neg = m.aneg ^ x_neg;
    o.plo = m.ua[DATA_W-1:0] * x_mag;
    o.phi = m.ua[ACC_W-1:DATA_W] * x_mag;
    return o;
  endfunction

  // join partial products, round half away from zero on the magnitude, check range
  function automatic rnd_t rnd_f(mul_t m);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sh;
    rnd_t o;
    prod   = {{DATA_W{1'b0}}, m.plo} + {m.phi, {DATA_W{1'b0}}} + RND_ONE;
    sh     = prod >> FRAC_BITS;
    o.neg  = m.neg;
    o.mlo  = sh[ACC_W-1:0];
    o.povf = (|sh[PROD_W-1:ACC_W]) ||
             (sh[ACC_W-1] && (!m.neg || (|sh[ACC_W-2:0])));
    return o;
  endfunction

  // reapply sign and add the coefficient in one adder, saturate to 64 bits
  function automatic sum_t add_f(rnd_t r, logic signed [ACC_W-1:0] c);
    logic                    inv;
    logic [ACC_W:0]          opnd;
    logic signed [ACC_W+1:0] s;
    sum_t o;
    inv = r.neg && !r.povf;
    if (r.povf) begin
      opnd = r.neg ? {1'b1, ACC_MIN} : {1'b0, ACC_MAX};
    end else begin
      opnd = {1'b0, r.mlo} ^ {(ACC_W+1){inv}};
    end
    s = $signed({opnd[ACC_W], opnd}) + $signed({{2{c[ACC_W-1]}}, c}) +
        $signed({{(ACC_W+1){1'b0}}, inv});
    o.aovf = (s[ACC_W+1] != s[ACC_W]) || (s[ACC_W] != s[ACC_W-1]);
    o.acc  = o.aovf ? (s[ACC_W+1] ? ACC_MIN : ACC_MAX) : s[ACC_W-1:0];
    return o;
  endfunction

  ctl_t ctl_in;
  ctl_t c1;
  ctl_t c2;
  ctl_t c3;
  mag_t vm;
  mul_t vp;
  rnd_t vr;
  sum_t vsum;
  logic signed [ACC_W-1:0] der_acc;
  logic                    der_flag;

  assign ctl_in = '{vld: item_in.vld, ovf: item_in.ovf,
                    x_neg: item_in.x_neg, x_mag: item_in.x_mag};
  assign vsum   = add_f(vr, addend.val);

  if (SLOPE_ON) begin : g_slope
    mag_t dm;
    mul_t dp;
    rnd_t dr;
    sum_t dsum;

    always_ff @(posedge clk) begin
      if (adv) begin
        dm <= mag_f(item_in.der);
        dp <= mul_f(dm, c1.x_mag, c1.x_neg);
        dr <= rnd_f(dp);
      end
    end

    assign dsum     = add_f(dr, addend.der);
    assign der_acc  = dsum.acc;
    assign der_flag = dr.povf | dsum.aovf;
  end else begin : g_pass
    // slope has one step fewer: just keep it aligned with the value lane
    logic signed [ACC_W-1:0] d1;
    logic signed [ACC_W-1:0] d2;
    logic signed [ACC_W-1:0] d3;

    always_ff @(posedge clk) begin
      if (adv) begin
        d1 <= item_in.der;
        d2 <= d1;
        d3 <= d2;
      end
    end

    assign der_acc  = d3;
    assign der_flag = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.vld       <= 1'b0;
      c2.vld       <= 1'b0;
      c3.vld       <= 1'b0;
      item_out.vld <= 1'b0;
    end else if (adv) begin
      c1 <= ctl_in;
      c2 <= c1;
      c3 <= c2;
      vm <= mag_f(item_in.val);
      vp <= mul_f(vm, c1.x_mag, c1.x_neg);
      vr <= rnd_f(vp);
      item_out.vld   <= c3.vld;
      item_out.ovf   <= c3.ovf | vr.povf | vsum.aovf | der_flag;
      item_out.x_neg <= c3.x_neg;
      item_out.x_mag <= c3.x_mag;
      item_out.val   <= vsum.acc;
      item_out.der   <= der_acc;
    end
  end

  `P6VS_ASSERT_NEXT(a_zero_prod_in_range, clk, rst, adv && c2.vld && vp.plo == '0 && vp.phi == '0, !vr.povf)
  `P6VS_ASSERT_NEXT(a_prod_ovf_flagged, clk, rst, adv && c3.vld && vr.povf, item_out.ovf)
  `P6VS_ASSERT_NEXT(a_hold_on_stall, clk, rst, !adv, $stable(item_out))

endmodule

@@ rtl/poly6_value_and_slope.sv @@
// degree-6 polynomial value and slope, signed fixed point, horner pipeline; uses p6vs_pkg,
// p6vs_horner_step and poly6_value_and_slope_macros.svh
// datapath: input register, six 4-stage horner steps, output clip register; throughput one
// transaction per cycle unless in_stall is raised; each step holds two 32x32 multipliers per
// lane (the last step has none in the slope lane) and a 96-bit round stage
// reset clears the valid bits and all coefficient registers to zero
`include "poly6_value_and_slope_macros.svh"
module poly6_value_and_slope #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [p6vs_pkg::ADDR_W-1:0]       paddr,
  input  logic [p6vs_pkg::DATA_W-1:0]       pwdata,
  output logic [p6vs_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [p6vs_pkg::DATA_W-1:0] strain_x,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [p6vs_pkg::DATA_W-1:0] poly_value,
  output logic signed [p6vs_pkg::DATA_W-1:0] poly_slope,
  output logic                              overflow
);
  import p6vs_pkg::*;

  logic [DATA_W-1:0]       coef  [NUM_COEF];
  logic signed [ACC_W-1:0] c_ext [NUM_COEF];
  logic [IDX_W-1:0]        idx;
  logic                    cfg_wr;
  logic                    adv;
  logic [DATA_W-1:0]       x_bits;
  logic signed [ACC_W-1:0] der_start;
  p6vs_item_t              in_reg;
  p6vs_item_t              chain  [NUM_STEPS+1];
  p6vs_addend_t            addend [NUM_STEPS];
  p6vs_item_t              last;
  logic                    v_over;
  logic                    v_under;
  logic                    d_over;
  logic                    d_under;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_COEF; k++) begin
        coef[k] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (idx)
        REG_A0:  coef[REG_A0] <= pwdata;
        REG_A1:  coef[REG_A1] <= pwdata;
        REG_A2:  coef[REG_A2] <= pwdata;
        REG_A3:  coef[REG_A3] <= pwdata;
        REG_A4:  coef[REG_A4] <= pwdata;
        REG_A5:  coef[REG_A5] <= pwdata;
        REG_A6:  coef[REG_A6] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_A0:  prdata = coef[REG_A0];
      REG_A1:  prdata = coef[REG_A1];
      REG_A2:  prdata = coef[REG_A2];
      REG_A3:  prdata = coef[REG_A3];
      REG_A4:  prdata = coef[REG_A4];
      REG_A5:  prdata = coef[REG_A5];
      REG_A6:  prdata = coef[REG_A6];
      default: prdata = '0;
    endcase
  end

  for (genvar k = 0; k < NUM_COEF; k++) begin : g_ext
    assign c_ext[k] = {{(ACC_W-DATA_W){coef[k][DATA_W-1]}}, coef[k]};
  end

  // value step s adds a(5-s); slope step s adds (5-s)*a(5-s), last slope step unused
  for (genvar s = 0; s < NUM_STEPS; s++) begin : g_add
    assign addend[s].val = c_ext[NUM_STEPS-1-s];
    assign addend[s].der = c_ext[NUM_STEPS-1-s] * ACC_W'(NUM_STEPS-1-s);
  end

  assign der_start = c_ext[NUM_COEF-1] * ACC_W'(NUM_STEPS);

  // whole pipeline moves unless the output register holds an untaken transaction
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign x_bits   = strain_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg.vld <= 1'b0;
    end else if (adv) begin
      in_reg.vld   <= in_valid;
      in_reg.ovf   <= 1'b0;
      in_reg.x_neg <= x_bits[DATA_W-1];
      in_reg.x_mag <= x_bits[DATA_W-1] ? (~x_bits + DATA_W'(1)) : x_bits;
      in_reg.val   <= c_ext[NUM_COEF-1];
      in_reg.der   <= der_start;
    end
  end

  assign chain[0] = in_reg;

  for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
    p6vs_horner_step #(
      .FRAC_BITS (FRAC_BITS),
      .SLOPE_ON  (s < NUM_STEPS - 1)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .item_in  (chain[s]),
      .addend   (addend[s]),
      .item_out (chain[s+1])
    );
  end

  // final clip to 32 bits
  assign last    = chain[NUM_STEPS];
  assign v_over  = !last.val[ACC_W-1] && (|last.val[ACC_W-2:DATA_W-1]);
  assign v_under = last.val[ACC_W-1] && !(&last.val[ACC_W-2:DATA_W-1]);
  assign d_over  = !last.der[ACC_W-1] && (|last.der[ACC_W-2:DATA_W-1]);
  assign d_under = last.der[ACC_W-1] && !(&last.der[ACC_W-2:DATA_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid  <= last.vld;
      poly_value <= v_over ? OUT_MAX : (v_under ? OUT_MIN : last.val[DATA_W-1:0]);
      poly_slope <= d_over ? OUT_MAX : (d_under ? OUT_MIN : last.der[DATA_W-1:0]);
      overflow   <= last.ovf | v_over | v_under | d_over | d_under;
    end
  end

  `P6VS_ASSERT_NEXT(a_wide_ovf_reaches_out, clk, rst, !in_stall && last.vld && last.ovf, out_valid && overflow)
  `P6VS_ASSERT_NEXT(a_pipe_holds, clk, rst, in_stall, $stable(chain[0]) && $stable(last))
  `P6VS_ASSERT_NEXT(a_out_from_pipe, clk, rst, !in_stall && !last.vld, !out_valid)

endmodule
